// ----- rtl/core/tphp_pkg.sv -----
`timescale 1ns / 1ps
package tphp_pkg;

  localparam int unsigned HistDepthDefault = 1024;
  localparam logic [31:0] VelWindowReset = 32'd120000;
  localparam logic [31:0] MaxHorizonReset = 32'd400000;

  localparam logic [1:0] SRC_EMPTY = 2'd0;
  localparam logic [1:0] SRC_HIT = 2'd1;
  localparam logic [1:0] SRC_OLDEST = 2'd2;
  localparam logic [1:0] SRC_PREDICT = 2'd3;

  localparam logic CFG_VEL_WINDOW = 1'b0;
  localparam logic CFG_MAX_HORIZON = 1'b1;

  typedef struct packed {
    logic kind;
    logic [63:0] time_stamp;
    logic signed [31:0] delta_x;
    logic signed [31:0] delta_y;
    logic absolute_mode;
  } in_word_t;

  typedef struct packed {
    logic signed [63:0] pos_x;
    logic signed [63:0] pos_y;
    logic [1:0] source;
  } out_word_t;

  typedef struct packed {
    logic [63:0] t;
    logic [63:0] x;
    logic [63:0] y;
  } hist_entry_t;

endpackage

// ----- rtl/core/tphp_divider.sv -----
`timescale 1ns / 1ps
module tphp_divider import tphp_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [63:0]  delta,
  input  logic [31:0]  h,
  input  logic [63:0]  dt,
  output logic         done,
  output logic [63:0]  quo
);

  typedef enum logic [3:0] {
    D_IDLE = 4'b0001,
    D_MUL0 = 4'b0010,
    D_MUL1 = 4'b0100,
    D_DIV  = 4'b1000
  } dstate_t;

  dstate_t state_r, state_nxt;
  logic [63:0] mag_r, dt_r, quo_r, rem_r;
  logic [31:0] h_r;
  logic [127:0] prod_r;
  logic neg_r;
  logic [6:0] cnt_r;
  logic [64:0] rem_sh;
  logic [63:0] pp;

  assign pp = mag_r[31:0] * h_r;
  assign rem_sh = {rem_r, prod_r[127]};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      D_IDLE: if (start) state_nxt = D_MUL0;
      D_MUL0: state_nxt = D_MUL1;
      D_MUL1: state_nxt = D_DIV;
      D_DIV:  if (cnt_r == 7'd127) state_nxt = D_IDLE;
      default: state_nxt = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done <= (state_r == D_DIV) && (cnt_r == 7'd127);
    end
    unique case (state_r)
      D_IDLE: begin
        neg_r <= delta[63];
        mag_r <= delta[63] ? (~delta + 64'd1) : delta;
        h_r <= h;
        dt_r <= dt;
      end
      D_MUL0: begin
        prod_r <= {64'd0, pp};
        mag_r <= {32'd0, mag_r[63:32]};
      end
      D_MUL1: begin
        prod_r <= prod_r + {32'd0, pp, 32'd0};
        rem_r <= '0;
        quo_r <= '0;
        cnt_r <= '0;
      end
      D_DIV: begin
        prod_r <= {prod_r[126:0], 1'b0};
        cnt_r <= cnt_r + 7'd1;
        if (rem_sh >= {1'b0, dt_r}) begin
          rem_r <= 64'(rem_sh - {1'b0, dt_r});
          quo_r <= {quo_r[62:0], 1'b1};
        end else begin
          rem_r <= rem_sh[63:0];
          quo_r <= {quo_r[62:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  assign quo = neg_r ? (~quo_r + 64'd1) : quo_r;

  a_done_from_div: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> $past(state_r == D_DIV)) else $error("done without divide");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == D_MUL0) |-> $past(start)) else $error("multiply without start");
  a_cnt_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == D_DIV && cnt_r != 7'd127) |=> (state_r == D_DIV))
    else $error("divide stopped early");

endmodule

// ----- rtl/core/timestamped_position_history_predictor.sv -----
`timescale 1ns / 1ps
// A motion word is accepted in S_IDLE and written to memory in S_WR; an absolute-mode motion word is ignored.
// A query reads the newest entry in S_NEW and S_NEWD, then passes S_WALK and S_WDATA per entry walked.
// A past query may walk all HISTORY_DEPTH entries.
// A predicted query adds two 64-bit divides, x and then y, through one divider when the time difference is positive.
// Throughput is one word at a time; a pending result word holds off the next input word.
// Synchronous active-low reset clears state, accumulators, pointers, config and out_valid; memory is not cleared.
module timestamped_position_history_predictor import tphp_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = HistDepthDefault
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_word_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_word_t  out_data,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int CW = $clog2(HISTORY_DEPTH + 1);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_NEW   = 9'b000000010,
    S_NEWD  = 9'b000000100,
    S_WALK  = 9'b000001000,
    S_WDATA = 9'b000010000,
    S_DIVX  = 9'b000100000,
    S_DIVY  = 9'b001000000,
    S_OUT   = 9'b010000000,
    S_WR    = 9'b100000000
  } state_t;

  hist_entry_t mem [HISTORY_DEPTH];
  hist_entry_t rd_r, nw_r;
  logic [AW-1:0] rd_addr;
  logic rd_en;

  state_t state_r;
  logic [31:0] vel_win_r, max_hor_r;
  logic [63:0] tot_x_r, tot_y_r;
  logic [AW-1:0] wp_r;
  logic [CW-1:0] fill_r, k_r;
  logic [63:0] ts_r;
  logic future_r;
  out_word_t res_r;
  logic out_valid_r;

  logic [63:0] age, nx_x, nx_y, hdiff, dt_v, quo;
  logic [31:0] hsel;
  logic div_start, div_done;
  logic [63:0] div_delta;
  logic walk_stop, dt_ok;

  function automatic logic [AW-1:0] back(input logic [AW-1:0] wp, input logic [CW-1:0] k);
    logic [CW:0] s;
    s = {1'b0, CW'(wp)} + (CW+1)'(HISTORY_DEPTH) - {1'b0, k};
    if (s >= (CW+1)'(HISTORY_DEPTH)) s = s - (CW+1)'(HISTORY_DEPTH);
    return s[AW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (state_r == S_WR) mem[wp_r] <= '{t: ts_r, x: tot_x_r, y: tot_y_r};
    if (rd_en) rd_r <= mem[rd_addr];
  end

  assign in_stall = (state_r != S_IDLE) || out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data = res_r;
  assign rd_addr = back(wp_r, k_r);
  assign rd_en = (state_r == S_NEW) || (state_r == S_WALK);

  assign age = nw_r.t - rd_r.t;
  assign dt_v = nw_r.t - rd_r.t;
  assign hdiff = ts_r - nw_r.t;
  assign hsel = (hdiff > {32'd0, max_hor_r}) ? max_hor_r : hdiff[31:0];
  assign walk_stop = (!age[63] && age >= {32'd0, vel_win_r}) || k_r == fill_r ||
                     fill_r == CW'(1);
  assign dt_ok = !dt_v[63] && dt_v != '0;
  assign div_start = (state_r == S_WDATA && future_r && walk_stop && dt_ok) ||
                     (state_r == S_DIVX && div_done);
  assign div_delta = (state_r == S_DIVX) ? (nw_r.y - rd_r.y) : (nw_r.x - rd_r.x);
  assign nx_x = nw_r.x + quo;
  assign nx_y = nw_r.y + quo;

  tphp_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .delta(div_delta),
    .h(hsel), .dt(dt_v), .done(div_done), .quo(quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      vel_win_r <= VelWindowReset;
      max_hor_r <= MaxHorizonReset;
      tot_x_r <= '0;
      tot_y_r <= '0;
      wp_r <= '0;
      fill_r <= '0;
      out_valid_r <= 1'b0;
      k_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_VEL_WINDOW:  vel_win_r <= cfg_wdata;
          CFG_MAX_HORIZON: max_hor_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_valid && !in_stall) begin
          ts_r <= in_data.time_stamp;
          if (!in_data.kind) begin
            if (!in_data.absolute_mode) begin
              tot_x_r <= tot_x_r + 64'(signed'(in_data.delta_x));
              tot_y_r <= tot_y_r + 64'(signed'(in_data.delta_y));
              state_r <= S_WR;
            end
          end else if (fill_r == '0) begin
            res_r <= '{pos_x: tot_x_r, pos_y: tot_y_r, source: SRC_EMPTY};
            out_valid_r <= 1'b1;
          end else begin
            k_r <= CW'(1);
            state_r <= S_NEW;
          end
        end
        S_WR: begin
          wp_r <= (wp_r == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_r + AW'(1);
          if (fill_r != CW'(HISTORY_DEPTH)) fill_r <= fill_r + CW'(1);
          state_r <= S_IDLE;
        end
        S_NEW: state_r <= S_NEWD;
        S_NEWD: begin
          nw_r <= rd_r;
          future_r <= ts_r > rd_r.t;
          if (ts_r > rd_r.t) begin
            if (fill_r == CW'(1)) begin
              state_r <= S_WDATA;
            end else begin
              k_r <= CW'(2);
              state_r <= S_WALK;
            end
          end else begin
            state_r <= S_WALK;
          end
        end
        S_WALK: state_r <= S_WDATA;
        S_WDATA: begin
          if (future_r) begin
            if (walk_stop) begin
              if (dt_ok) begin
                state_r <= S_DIVX;
              end else begin
                res_r <= '{pos_x: nw_r.x, pos_y: nw_r.y, source: SRC_PREDICT};
                out_valid_r <= 1'b1;
                state_r <= S_IDLE;
              end
            end else begin
              k_r <= k_r + CW'(1);
              state_r <= S_WALK;
            end
          end else if (rd_r.t <= ts_r) begin
            res_r <= '{pos_x: rd_r.x, pos_y: rd_r.y, source: SRC_HIT};
            out_valid_r <= 1'b1;
            state_r <= S_IDLE;
          end else if (k_r == fill_r) begin
            res_r <= '{pos_x: rd_r.x, pos_y: rd_r.y, source: SRC_OLDEST};
            out_valid_r <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            k_r <= k_r + CW'(1);
            state_r <= S_WALK;
          end
        end
        S_DIVX: if (div_done) begin
          res_r.pos_x <= nx_x;
          state_r <= S_DIVY;
        end
        S_DIVY: if (div_done) begin
          res_r.pos_y <= nx_y;
          res_r.source <= SRC_PREDICT;
          out_valid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> in_stall) else $error("accepted while result pending");
  a_fill_max: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(HISTORY_DEPTH)) else $error("fill count overflow");
  a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> (k_r <= fill_r && k_r != '0)) else $error("walk out of range");

endmodule

// ----- test/timestamped_position_history_predictor_checker.sv -----
`timescale 1ns / 1ps
module timestamped_position_history_predictor_checker import tphp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_word_t    in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_word_t   out_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata,
  output int          fail_count,
  output int          pending
);

  localparam int unsigned Depth = HistDepthDefault;

  logic [63:0] vel_window;
  logic [63:0] horizon_cap;
  logic [63:0] sum_x;
  logic [63:0] sum_y;
  logic [63:0] trail_t [Depth];
  logic [63:0] trail_x [Depth];
  logic [63:0] trail_y [Depth];
  logic [9:0]  next_slot;
  int          entries;
  out_word_t   expected_positions[$];

  function automatic logic [63:0] scaled_step(logic [63:0] delta, logic [63:0] h,
                                              logic [63:0] dt);
    logic [63:0]  mag;
    logic [127:0] prod;
    logic [127:0] quo;
    mag = delta[63] ? -delta : delta;
    prod = {64'd0, mag} * {64'd0, h};
    quo = prod / {64'd0, dt};
    return delta[63] ? -quo[63:0] : quo[63:0];
  endfunction

  function automatic out_word_t predict_position(logic [63:0] target);
    out_word_t   r;
    logic [9:0]  nw;
    logic [9:0]  od;
    logic [63:0] nt;
    logic [63:0] age;
    logic [63:0] h;
    r.source = SRC_EMPTY;
    r.pos_x = sum_x;
    r.pos_y = sum_y;
    if (entries == 0) return r;
    nw = next_slot - 10'd1;
    nt = trail_t[nw];
    if (target > nt) begin
      od = nw;
      for (int k = 2; k <= entries; k++) begin
        od = next_slot - 10'(k);
        age = nt - trail_t[od];
        if (!age[63] && age >= vel_window) break;
      end
      age = nt - trail_t[od];
      r.source = SRC_PREDICT;
      r.pos_x = trail_x[nw];
      r.pos_y = trail_y[nw];
      if (!age[63] && age != 0) begin
        h = target - nt;
        if (h > horizon_cap) h = horizon_cap;
        r.pos_x = trail_x[nw] + scaled_step(trail_x[nw] - trail_x[od], h, age);
        r.pos_y = trail_y[nw] + scaled_step(trail_y[nw] - trail_y[od], h, age);
      end
      return r;
    end
    for (int k = 1; k <= entries; k++) begin
      od = next_slot - 10'(k);
      if (trail_t[od] <= target) begin
        r.source = SRC_HIT;
        r.pos_x = trail_x[od];
        r.pos_y = trail_y[od];
        return r;
      end
    end
    od = next_slot - 10'(entries);
    r.source = SRC_OLDEST;
    r.pos_x = trail_x[od];
    r.pos_y = trail_y[od];
    return r;
  endfunction

  assign pending = expected_positions.size();

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      vel_window = {32'd0, VelWindowReset};
      horizon_cap = {32'd0, MaxHorizonReset};
      sum_x = '0;
      sum_y = '0;
      next_slot = '0;
      entries = 0;
      fail_count = 0;
      expected_positions.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_positions.size() == 0) begin
          $error("Result word arrived with no expectation pending");
          fail_count++;
        end else begin
          want = expected_positions.pop_front();
          if (out_data.pos_x !== want.pos_x) begin
            $error("pos_x expected %0h actual %0h", want.pos_x, out_data.pos_x);
            fail_count++;
          end
          if (out_data.pos_y !== want.pos_y) begin
            $error("pos_y expected %0h actual %0h", want.pos_y, out_data.pos_y);
            fail_count++;
          end
          if (out_data.source !== want.source) begin
            $error("source expected %0d actual %0d", want.source, out_data.source);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_data.kind) begin
          expected_positions.push_back(predict_position(in_data.time_stamp));
        end else if (!in_data.absolute_mode) begin
          sum_x = sum_x + {{32{in_data.delta_x[31]}}, in_data.delta_x};
          sum_y = sum_y + {{32{in_data.delta_y[31]}}, in_data.delta_y};
          trail_t[next_slot] = in_data.time_stamp;
          trail_x[next_slot] = sum_x;
          trail_y[next_slot] = sum_y;
          next_slot = next_slot + 10'd1;
          if (entries < Depth) entries++;
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_VEL_WINDOW) vel_window = {32'd0, cfg_wdata};
        else horizon_cap = {32'd0, cfg_wdata};
      end
    end
  end

endmodule

// ----- test/timestamped_position_history_predictor_test.sv -----
`timescale 1ns / 1ps
module timestamped_position_history_predictor_test import tphp_pkg::*;;

  localparam int StallLimit = 20000;
  localparam int PhaseItems = 190;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_word_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_word_t   out_data;
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_wdata;
  int          fail_count;
  int          pending;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          quiet_cycles;
  logic [63:0] clock_now;

  timestamped_position_history_predictor dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  timestamped_position_history_predictor_checker checker_inst (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic send_word(in_word_t w);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_motion(logic [63:0] ts, logic [31:0] dx, logic [31:0] dy,
                             logic abs_mode);
    in_word_t w;
    w.kind = 1'b0;
    w.time_stamp = ts;
    w.delta_x = dx;
    w.delta_y = dy;
    w.absolute_mode = abs_mode;
    send_word(w);
  endtask

  task automatic send_query(logic [63:0] ts);
    in_word_t w;
    w.kind = 1'b1;
    w.time_stamp = ts;
    w.delta_x = $urandom;
    w.delta_y = $urandom;
    w.absolute_mode = 1'($urandom_range(0, 1));
    send_word(w);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_word;
    logic [63:0] ts;
    logic [31:0] dx;
    logic [31:0] dy;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 72) begin
      pick = $urandom_range(0, 99);
      if (pick < 88) begin
        clock_now = clock_now + $urandom_range(1, 60000);
        ts = clock_now;
      end else if (pick < 95) begin
        ts = clock_now - $urandom_range(0, 90000);
      end else begin
        ts = {$urandom, $urandom};
      end
      if ($urandom_range(0, 4) == 0) begin
        dx = $urandom;
        dy = $urandom;
      end else begin
        dx = $urandom_range(0, 400) - 200;
        dy = $urandom_range(0, 400) - 200;
      end
      send_motion(ts, dx, dy, $urandom_range(0, 19) == 0);
    end else begin
      pick = $urandom_range(0, 9);
      if (pick < 4) ts = clock_now - $urandom_range(0, 2000000);
      else if (pick < 8) ts = clock_now + $urandom_range(1, 1000000);
      else if (pick == 8) ts = {$urandom, $urandom};
      else ts = $urandom_range(0, 1) ? '0 : '1;
      send_query(ts);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_VEL_WINDOW;
    cfg_wdata = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    clock_now = 64'd100000;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_query(64'd0);
    send_motion(64'd5, 32'h7fffffff, 32'h80000000, 1'b1);
    send_query('1);
    send_motion(64'd1000, 32'h7fffffff, 32'h80000000, 1'b0);
    send_motion(64'd2000, 32'h80000000, 32'h7fffffff, 1'b0);
    send_query(64'd0);
    send_query(64'd1000);
    send_query(64'd1500);
    send_query('1);
    send_motion(64'd2000, 32'd3, 32'hfffffffd, 1'b0);
    send_query(64'd2500);
    send_motion(64'd500, 32'd40, 32'd12, 1'b0);
    send_query(64'd600);
    send_motion(64'd300000, 32'h7fffffff, 32'h7fffffff, 1'b0);
    send_query(64'd900000);
    send_motion('1, 32'hffffffff, 32'd1, 1'b0);
    send_query('1);
    send_query(64'd1);
    drain();

    write_reg(CFG_VEL_WINDOW, 32'd0);
    write_reg(CFG_MAX_HORIZON, 32'hffffffff);
    send_idle_pct = 15;
    recv_idle_pct = 48;
    repeat (PhaseItems) random_word();
    drain();

    write_reg(CFG_VEL_WINDOW, 32'hffffffff);
    write_reg(CFG_MAX_HORIZON, 32'd0);
    send_idle_pct = 48;
    recv_idle_pct = 15;
    repeat (PhaseItems) random_word();
    drain();

    write_reg(CFG_VEL_WINDOW, $urandom_range(1000, 200000));
    write_reg(CFG_MAX_HORIZON, $urandom);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (PhaseItems) random_word();
    drain();

    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/tphp_pkg.sv
rtl/core/tphp_divider.sv
rtl/core/timestamped_position_history_predictor.sv
test/timestamped_position_history_predictor_checker.sv
test/timestamped_position_history_predictor_test.sv
